/* hdl/linear_probe_hash_table_core_macros.svh */
// assertion macros for the hash table core
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LPHT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define LPHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`endif

/* hdl/lpht_pkg.sv */
`default_nettype none

package lpht_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int KEY_WIDTH_DEF   = 32;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int CAP_WIDTH       = 9;
   localparam int CAP_RESET       = 256;
   localparam int MOD_RADIX_BITS  = 4;
   localparam int ACTION_WIDTH    = 2;
   localparam int STATUS_WIDTH    = 3;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   typedef struct packed {
      logic       load;
      logic       mod_step;
      logic       probe_start;
      logic       probe_next;
      logic       write_entry;
      logic       clr_start;
      logic       clr_full;
      logic       clr_step;
      logic       rsp_valid;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic is_insert;
      logic mod_done;
      logic entry_valid;
      logic key_match;
      logic probe_last;
      logic clr_last;
   } sts_type;

endpackage

`default_nettype wire

/* hdl/lpht_ram.sv */
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 1 + lpht_pkg::KEY_WIDTH_DEF + lpht_pkg::VALUE_WIDTH_DEF,
   parameter int DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/lpht_ctrl.sv */
`default_nettype none

module lpht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              csr_we,
   input  wire lpht_pkg::sts_type sts,
   output lpht_pkg::cmd_type      cmd,
   output logic                   busy
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CLEAR = 5'b00010,
      S_MOD   = 5'b00100,
      S_PROBE = 5'b01000,
      S_CHECK = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      clr_rsp_ff, clr_rsp_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (sts.req_clear) begin
                  cmd.clr_start = 1'b1;
                  clr_rsp_in    = 1'b1;
                  state_in      = S_CLEAR;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               cmd.rsp_valid  = clr_rsp_ff;
               cmd.rsp_status = lpht_pkg::ST_CLEARED;
               state_in       = S_IDLE;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            cmd.probe_start = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            priority if (!sts.entry_valid) begin
               cmd.rsp_valid = 1'b1;
               state_in      = S_IDLE;
               if (sts.is_insert) begin
                  cmd.write_entry = 1'b1;
                  cmd.rsp_status  = lpht_pkg::ST_INSERTED;
               end else begin
                  cmd.rsp_status = lpht_pkg::ST_NOT_FOUND;
               end
            end else if (sts.key_match) begin
               cmd.rsp_valid  = 1'b1;
               state_in       = S_IDLE;
               cmd.rsp_status = sts.is_insert ? lpht_pkg::ST_DUPLICATE : lpht_pkg::ST_FOUND;
            end else if (sts.probe_last) begin
               cmd.rsp_valid  = 1'b1;
               state_in       = S_IDLE;
               cmd.rsp_status = sts.is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // capacity write empties the whole table
      if (csr_we) begin
         cmd           = '0;
         cmd.clr_start = 1'b1;
         cmd.clr_full  = 1'b1;
         clr_rsp_in    = 1'b0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

/* hdl/lpht_dp.sv */
`default_nettype none

module lpht_dp #(
   parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_WIDTH   = lpht_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [lpht_pkg::ACTION_WIDTH-1:0] req_action,
   input  wire logic [KEY_WIDTH-1:0]              req_key,
   input  wire logic [VALUE_WIDTH-1:0]            req_value,
   input  wire logic                              csr_we,
   input  wire logic [lpht_pkg::CAP_WIDTH-1:0]    csr_wdata,
   input  wire lpht_pkg::cmd_type                 cmd,
   output lpht_pkg::sts_type                      sts,
   output logic                                   rsp_valid,
   output logic [lpht_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [VALUE_WIDTH-1:0]                 rsp_read_value
);

   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = IDX_W + 1;
   localparam int REM_W     = IDX_W + 2;
   localparam int RAD       = lpht_pkg::MOD_RADIX_BITS;
   localparam int MOD_STEPS = (KEY_WIDTH + RAD - 1) / RAD;
   localparam int KEY_PAD   = MOD_STEPS * RAD;
   localparam int STEP_W    = $clog2(MOD_STEPS + 1);
   localparam int ENTRY_W   = 1 + KEY_WIDTH + VALUE_WIDTH;
   localparam int CAP_RST   = (lpht_pkg::CAP_RESET > TABLE_DEPTH) ? TABLE_DEPTH
                                                                  : lpht_pkg::CAP_RESET;

   logic [lpht_pkg::ACTION_WIDTH-1:0] act_ff, act_in;
   logic [KEY_WIDTH-1:0]              key_ff, key_in;
   logic [VALUE_WIDTH-1:0]            val_ff, val_in;
   logic [KEY_PAD-1:0]                kshift_ff, kshift_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic [IDX_W-1:0]                  slot_ff, slot_in;
   logic [IDX_W-1:0]                  cnt_ff, cnt_in;
   logic [IDX_W-1:0]                  clr_lim_ff, clr_lim_in;
   logic [CNT_W-1:0]                  cap_ff, cap_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   lpht_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0]            rsp_value_ff, rsp_value_in;

   logic [CNT_W-1:0]   cap_m1;
   logic [IDX_W-1:0]   slot_nx;
   logic [IDX_W-1:0]   rem_nx;
   logic [31:0]        cap_wr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   assign cap_m1  = cap_ff - 1'b1;
   assign slot_nx = (slot_ff == cap_m1[IDX_W-1:0]) ? '0 : slot_ff + 1'b1;
   assign cap_wr  = 32'(csr_wdata);

   // key modulo capacity, RAD restoring steps per cycle
   always_comb begin
      logic [REM_W-1:0] r;
      r = REM_W'(slot_ff);
      for (int j = 0; j < RAD; j++) begin
         r = {r[REM_W-2:0], kshift_ff[KEY_PAD-1-j]};
         if (r >= REM_W'(cap_ff)) begin
            r = r - REM_W'(cap_ff);
         end
      end
      rem_nx = r[IDX_W-1:0];
   end

   always_comb begin
      act_in     = act_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      kshift_in  = kshift_ff;
      step_in    = step_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      clr_lim_in = clr_lim_ff;
      cap_in     = cap_ff;
      if (cmd.load) begin
         act_in    = req_action;
         key_in    = req_key;
         val_in    = req_value;
         kshift_in = KEY_PAD'(req_key);
         step_in   = '0;
         slot_in   = '0;
      end
      if (cmd.mod_step) begin
         kshift_in = kshift_ff << RAD;
         step_in   = step_ff + 1'b1;
         slot_in   = rem_nx;
      end
      if (cmd.probe_start) begin
         cnt_in = '0;
      end
      if (cmd.probe_next) begin
         slot_in = slot_nx;
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.clr_start) begin
         cnt_in     = '0;
         clr_lim_in = cmd.clr_full ? IDX_W'(TABLE_DEPTH - 1) : cap_m1[IDX_W-1:0];
      end
      if (cmd.clr_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (csr_we) begin
         priority if (cap_wr == 32'd0) begin
            cap_in = CNT_W'(1);
         end else if (cap_wr > 32'(TABLE_DEPTH)) begin
            cap_in = CNT_W'(TABLE_DEPTH);
         end else begin
            cap_in = CNT_W'(cap_wr);
         end
      end
   end

   assign wr_en   = cmd.write_entry | cmd.clr_step;
   assign wr_addr = cmd.clr_step ? cnt_ff : slot_ff;
   assign wr_data = cmd.clr_step ? '0 : {1'b1, key_ff, val_ff};
   assign rd_addr = cmd.probe_next ? slot_nx : slot_ff;

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.req_clear   = (req_action == lpht_pkg::ACT_CLEAR);
   assign sts.is_insert   = (act_ff == lpht_pkg::ACT_INSERT);
   assign sts.mod_done    = (step_ff == STEP_W'(MOD_STEPS - 1));
   assign sts.entry_valid = rd_data[ENTRY_W-1];
   assign sts.key_match   = (rd_data[ENTRY_W-2 -: KEY_WIDTH] == key_ff);
   assign sts.probe_last  = (cnt_ff == cap_m1[IDX_W-1:0]);
   assign sts.clr_last    = (cnt_ff == clr_lim_ff);

   assign rsp_valid_in  = cmd.rsp_valid;
   assign rsp_status_in = cmd.rsp_status;
   assign rsp_value_in  = (cmd.rsp_status == lpht_pkg::ST_FOUND) ? rd_data[VALUE_WIDTH-1:0]
                                                                 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CNT_W'(CAP_RST);
         cnt_ff       <= '0;
         clr_lim_ff   <= IDX_W'(TABLE_DEPTH - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         cnt_ff       <= cnt_in;
         clr_lim_ff   <= clr_lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      kshift_ff     <= kshift_in;
      step_ff       <= step_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

`default_nettype wire

/* hdl/linear_probe_hash_table_core.sv */
// insert/lookup: S_MOD takes the key modulo capacity, S_PROBE reads the home slot, S_CHECK
// probes P slots (1..capacity), then a registered response strobe; the key-mod-capacity unit
// takes 4 key bits a cycle, the table one probe a cycle
// clear: one table entry written per cycle, entries 0..capacity-1, then a registered strobe
// one request at a time, next start at the edge ending the strobe; the receiver cannot stall
// reset (sync, active high) and each capacity write clear all TABLE_DEPTH entries, busy high
`default_nettype none

`include "linear_probe_hash_table_core_macros.svh"

module linear_probe_hash_table_core #(
   parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_WIDTH   = lpht_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [lpht_pkg::ACTION_WIDTH-1:0] req_action,
   input  wire logic [KEY_WIDTH-1:0]              req_key,
   input  wire logic [VALUE_WIDTH-1:0]            req_value,
   output logic                                   rsp_valid,
   output logic [lpht_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [VALUE_WIDTH-1:0]                 rsp_read_value,
   input  wire logic                              csr_we,
   input  wire logic [lpht_pkg::CAP_WIDTH-1:0]    csr_wdata
);

   lpht_pkg::cmd_type cmd;
   lpht_pkg::sts_type sts;

   lpht_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .csr_we (csr_we),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   lpht_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   `LPHT_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   `LPHT_ASSERT_NEXT(a_accept_busy, start && !busy && !csr_we, busy)
   `LPHT_ASSERT_NOW(a_rd_zero, rsp_valid && rsp_status != lpht_pkg::ST_FOUND, rsp_read_value == '0)

endmodule

`default_nettype wire

/* verif/tb_linear_probe_hash_table_core.sv */
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_core;

   localparam int DEPTH = lpht_pkg::TABLE_DEPTH_DEF;
   localparam int KW    = lpht_pkg::KEY_WIDTH_DEF;
   localparam int VW    = lpht_pkg::VALUE_WIDTH_DEF;
   localparam int AW    = lpht_pkg::ACTION_WIDTH;
   localparam int SW    = lpht_pkg::STATUS_WIDTH;
   localparam int CW    = lpht_pkg::CAP_WIDTH;

   localparam logic [AW-1:0] ACT_UNUSED = 2'd3;
   localparam int TOTAL_PHASES = 10;
   localparam int PHASE_ITEMS  = 83;
   localparam int KEY_POOL_MAX = 48;

   typedef struct {
      lpht_pkg::status_type status;
      logic [VW-1:0]        read_value;
   } response_type;

   class probe_table_tracker_type;
      bit             slot_used[DEPTH];
      logic [KW-1:0]  slot_key[DEPTH];
      logic [VW-1:0]  slot_val[DEPTH];
      int unsigned    cap;
      response_type   pending[$];
      int             failures;
      int             status_seen[6];

      function new();
         cap = lpht_pkg::CAP_RESET;
         failures = 0;
         empty_slots();
      endfunction

      function void empty_slots();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
      endfunction

      function void write_capacity(logic [CW-1:0] w);
         if (w == 0) begin
            cap = 1;
         end else if (w > DEPTH) begin
            cap = DEPTH;
         end else begin
            cap = w;
         end
         empty_slots();
      endfunction

      function void note_request(logic [AW-1:0] act, logic [KW-1:0] k, logic [VW-1:0] v);
         response_type r;
         int unsigned  slot;
         int unsigned  n;
         r.status = lpht_pkg::ST_NOT_FOUND;
         r.read_value = '0;
         slot = k % cap;
         if (act == lpht_pkg::ACT_CLEAR) begin
            empty_slots();
            r.status = lpht_pkg::ST_CLEARED;
         end else if (act == lpht_pkg::ACT_INSERT) begin
            r.status = lpht_pkg::ST_FULL;
            for (n = 0; n < cap; n++) begin
               if (!slot_used[slot]) begin
                  slot_used[slot] = 1'b1;
                  slot_key[slot] = k;
                  slot_val[slot] = v;
                  r.status = lpht_pkg::ST_INSERTED;
                  break;
               end
               if (slot_key[slot] == k) begin
                  r.status = lpht_pkg::ST_DUPLICATE;
                  break;
               end
               slot = (slot + 1 == cap) ? 0 : slot + 1;
            end
         end else begin
            // lookup, and the unused code behaves the same
            for (n = 0; n < cap; n++) begin
               if (!slot_used[slot]) break;
               if (slot_key[slot] == k) begin
                  r.status = lpht_pkg::ST_FOUND;
                  r.read_value = slot_val[slot];
                  break;
               end
               slot = (slot + 1 == cap) ? 0 : slot + 1;
            end
         end
         pending.push_back(r);
      endfunction

      function void check_response(logic [SW-1:0] st, logic [VW-1:0] rv);
         response_type e;
         if (pending.size() == 0) begin
            $error("response with nothing outstanding: status %0d read_value %h", st, rv);
            failures++;
            return;
         end
         e = pending.pop_front();
         status_seen[e.status]++;
         if (st !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, st);
            failures++;
         end
         if (rv !== e.read_value) begin
            $error("read_value mismatch: expected %h, actual %h", e.read_value, rv);
            failures++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [AW-1:0]            req_action = lpht_pkg::ACT_INSERT;
   logic [KW-1:0]            req_key = '0;
   logic [VW-1:0]            req_value = '0;
   logic                     rsp_valid;
   logic [SW-1:0]            rsp_status;
   logic [VW-1:0]            rsp_read_value;
   logic                     csr_we = 1'b0;
   logic [CW-1:0]            csr_wdata = '0;

   probe_table_tracker_type  tracker = new();
   logic [KW-1:0]            known_keys[$];
   bit                       no_idle = 1'b0;
   int                       sent = 0;
   int                       writes = 0;

   linear_probe_hash_table_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         tracker.check_response(rsp_status, rsp_read_value);
      end
   end

   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mix of stored keys, keys crowding a few home slots around the wrap, and wide random keys
   function automatic logic [KW-1:0] pick_key(int unsigned cap);
      int unsigned   r;
      logic [KW-1:0] k;
      r = $urandom_range(0, 99);
      k = $urandom;
      if (r < 35 && known_keys.size() > 0) begin
         k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (r < 75) begin
         k = k - (k % cap) + ((cap - 2 + $urandom_range(0, 4)) % cap);
      end
      return k;
   endfunction

   task automatic issue(input logic [AW-1:0] act, input logic [KW-1:0] k,
                        input logic [VW-1:0] v);
      int unsigned g;
      start <= 1'b1;
      req_action <= act;
      req_key <= k;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      tracker.note_request(act, k, v);
      sent++;
      if (act == lpht_pkg::ACT_INSERT) begin
         known_keys.push_back(k);
         if (known_keys.size() > KEY_POOL_MAX) void'(known_keys.pop_front());
      end
      g = idle_cycles();
      if (g != 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending.size() != 0 || busy !== 1'b0);
   endtask

   task automatic set_capacity(input logic [CW-1:0] w);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_capacity(w);
      writes++;
   endtask

   task automatic run_random(input int count);
      logic [AW-1:0] act;
      int unsigned   r;
      int            n;
      for (n = 0; n < count; n++) begin
         if (n % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
         // drain the block mid phase
         if (n == count / 2) settle();
         r = $urandom_range(0, 99);
         if (r < 45) begin
            act = lpht_pkg::ACT_INSERT;
         end else if (r < 88) begin
            act = lpht_pkg::ACT_LOOKUP;
         end else if (r < 93) begin
            act = ACT_UNUSED;
         end else begin
            act = lpht_pkg::ACT_CLEAR;
         end
         issue(act, pick_key(tracker.cap), $urandom);
      end
   endtask

   initial begin : stimulus
      logic [CW-1:0] phase_caps[TOTAL_PHASES];
      int            p;
      phase_caps = '{9'd2, 9'd7, 9'd1, 9'd16, 9'd300, 9'd3, 9'd64, 9'd256, 9'd5, 9'd100};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      settle();

      // directed part at the reset capacity
      issue(lpht_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
      issue(lpht_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0);
      issue(lpht_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      issue(lpht_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_1234);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0100, 32'h0);
      issue(lpht_pkg::ACT_INSERT, 32'h0000_0100, 32'hA5A5_A5A5);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0100, 32'h0);
      issue(lpht_pkg::ACT_INSERT, 32'h0000_01FF, 32'h5A5A_5A5A);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_01FF, 32'h0);
      issue(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(lpht_pkg::ACT_CLEAR, 32'h0000_0000, 32'h0);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0);

      // zero capacity acts as a single slot
      set_capacity(9'd0);
      issue(lpht_pkg::ACT_INSERT, 32'h0000_0005, 32'h5A5A_5A5A);
      issue(lpht_pkg::ACT_INSERT, 32'h0000_0006, 32'h0000_0001);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0006, 32'h0);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0005, 32'h0);
      issue(lpht_pkg::ACT_INSERT, 32'h0000_0005, 32'h0000_0002);

      // oversized capacity clamps to the full table and empties it
      set_capacity(9'h1FF);
      issue(lpht_pkg::ACT_LOOKUP, 32'h0000_0005, 32'h0);
      issue(lpht_pkg::ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      issue(lpht_pkg::ACT_LOOKUP, 32'h8000_0000, 32'h0);

      for (p = 0; p < TOTAL_PHASES; p++) begin
         set_capacity(phase_caps[p]);
         run_random(PHASE_ITEMS);
      end

      settle();
      repeat (300) @(posedge clock);
      $display("%0d requests over %0d capacity writes, sizes 1 to 256 with clamping",
               sent, writes);
      $display("outcomes: ins %0d dup %0d full %0d found %0d miss %0d clr %0d",
               tracker.status_seen[lpht_pkg::ST_INSERTED],
               tracker.status_seen[lpht_pkg::ST_DUPLICATE],
               tracker.status_seen[lpht_pkg::ST_FULL],
               tracker.status_seen[lpht_pkg::ST_FOUND],
               tracker.status_seen[lpht_pkg::ST_NOT_FOUND],
               tracker.status_seen[lpht_pkg::ST_CLEARED]);
      if (tracker.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
